@@ hw/rtl/wrq_pkg.sv @@
// Shared types and constants for the witness requirement qualifier.
`default_nettype none

package wrq_pkg;

    localparam int MAX_REQUIREMENTS_DEFAULT = 16;
    localparam int MASK_W      = 16;
    localparam int TIME_W      = 48;
    localparam int WITNESS_W   = 16;
    localparam int QUALITY_W   = 8;
    localparam int GAP_W       = 32;
    localparam int COUNT_W     = 8;
    localparam int INDEX_W     = 4;
    localparam int CMD_W       = 2;
    localparam int CFG_W       = 8;

    localparam logic [COUNT_W-1:0] COUNT_SATURATION = '1;

    // input beat layout, lowest bit first
    localparam int IDX_LO   = 0;
    localparam int LWIT_LO  = IDX_LO + INDEX_W;
    localparam int LQUAL_LO = LWIT_LO + WITNESS_W;
    localparam int LGAP_LO  = LQUAL_LO + QUALITY_W;
    localparam int LNEED_LO = LGAP_LO + GAP_W;
    localparam int NOW_LO   = LNEED_LO + COUNT_W;
    localparam int PREV_LO  = NOW_LO + TIME_W;
    localparam int SWIT_LO  = PREV_LO + TIME_W;
    localparam int SQUAL_LO = SWIT_LO + WITNESS_W;
    localparam int IN_USED_W = SQUAL_LO + QUALITY_W;
    localparam int IN_DATA_W = ((IN_USED_W + 7) / 8) * 8;

    // result beat layout
    localparam int OUT_USED_W = 1 + MASK_W;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_BEGIN   = 2'd1,
        CMD_OBSERVE = 2'd2
    } cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/witness_requirement_qualifier_top.sv @@
// Witness requirement qualifier: requirement table, debt tracking and result register.
//
// Takes one beat per cycle while the result side is ready and returns one result beat per input
// beat from the result register. A load beat writes one table entry, a begin beat restarts
// binding, an observe beat checks the active table entries in parallel against one shared time
// subtraction and updates the consecutive-sample counter of each matching entry. The input and
// result registers decouple the two sides, so one new beat can be held while a result still
// waits. The requirement count register may only be written while no beat is in flight.
`default_nettype none

module witness_requirement_qualifier_top #(
    parameter int MAX_REQUIREMENTS = wrq_pkg::MAX_REQUIREMENTS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [wrq_pkg::CFG_W-1:0]     cfg_wr_data,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // entry_index, load_witness, load_min_quality, load_max_gap, load_needed_samples,
    // time_now, time_previous, sample_witness, sample_quality, zero fill
    input  wire logic [wrq_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // cmd
    input  wire logic [wrq_pkg::CMD_W-1:0]     s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // bound, owed_mask, zero fill
    output logic [wrq_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    localparam int NW  = $clog2(MAX_REQUIREMENTS + 1);
    localparam int TW  = wrq_pkg::TIME_W;
    localparam int MW  = wrq_pkg::MASK_W;
    localparam int CW  = wrq_pkg::COUNT_W;

    // ---------------- configuration ----------------
    logic [NW-1:0] active_n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_n_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_wr_data > wrq_pkg::CFG_W'(MAX_REQUIREMENTS))
            begin
                active_n_reg <= NW'(MAX_REQUIREMENTS);
            end
            else
            begin
                active_n_reg <= NW'(cfg_wr_data);
            end
        end
    end

    // ---------------- input register ----------------
    logic                              in_valid_reg;
    logic [wrq_pkg::CMD_W-1:0]         in_cmd_reg;
    logic [wrq_pkg::IN_USED_W-1:0]     in_data_reg;
    logic                              m_valid_reg;
    logic                              proc;

    assign proc          = in_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_cmd_reg  <= s_axis_tuser;
            in_data_reg <= s_axis_tdata[wrq_pkg::IN_USED_W-1:0];
        end
    end

    // field unpacking
    logic [wrq_pkg::INDEX_W-1:0]   f_index;
    logic [wrq_pkg::WITNESS_W-1:0] f_load_wit;
    logic [wrq_pkg::QUALITY_W-1:0] f_load_qual;
    logic [wrq_pkg::GAP_W-1:0]     f_load_gap;
    logic [CW-1:0]                 f_load_need;
    logic [TW-1:0]                 f_now;
    logic [TW-1:0]                 f_prev;
    logic [wrq_pkg::WITNESS_W-1:0] f_samp_wit;
    logic [wrq_pkg::QUALITY_W-1:0] f_samp_qual;

    assign f_index     = in_data_reg[wrq_pkg::IDX_LO   +: wrq_pkg::INDEX_W];
    assign f_load_wit  = in_data_reg[wrq_pkg::LWIT_LO  +: wrq_pkg::WITNESS_W];
    assign f_load_qual = in_data_reg[wrq_pkg::LQUAL_LO +: wrq_pkg::QUALITY_W];
    assign f_load_gap  = in_data_reg[wrq_pkg::LGAP_LO  +: wrq_pkg::GAP_W];
    assign f_load_need = in_data_reg[wrq_pkg::LNEED_LO +: CW];
    assign f_now       = in_data_reg[wrq_pkg::NOW_LO   +: TW];
    assign f_prev      = in_data_reg[wrq_pkg::PREV_LO  +: TW];
    assign f_samp_wit  = in_data_reg[wrq_pkg::SWIT_LO  +: wrq_pkg::WITNESS_W];
    assign f_samp_qual = in_data_reg[wrq_pkg::SQUAL_LO +: wrq_pkg::QUALITY_W];

    // ---------------- requirement table ----------------
    logic [wrq_pkg::WITNESS_W-1:0] wit_reg  [MAX_REQUIREMENTS];
    logic [wrq_pkg::QUALITY_W-1:0] qual_reg [MAX_REQUIREMENTS];
    logic [wrq_pkg::GAP_W-1:0]     gap_reg  [MAX_REQUIREMENTS];
    logic [CW-1:0]                 need_reg [MAX_REQUIREMENTS];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_REQUIREMENTS; i++)
        begin
            if (proc && in_cmd_reg == wrq_pkg::CMD_LOAD &&
                f_index == wrq_pkg::INDEX_W'(i))
            begin
                wit_reg[i]  <= f_load_wit;
                qual_reg[i] <= f_load_qual;
                gap_reg[i]  <= f_load_gap;
                need_reg[i] <= f_load_need;
            end
        end
    end

    // ---------------- binding state ----------------
    logic [MW-1:0] owed_reg;
    logic [MW-1:0] owed_next;
    logic          bound_reg;
    logic          bound_next;
    logic [TW-1:0] start_reg;
    logic [TW-1:0] start_next;
    logic [CW-1:0] cnt_reg  [MAX_REQUIREMENTS];
    logic [CW-1:0] cnt_next [MAX_REQUIREMENTS];

    // shared gap arithmetic
    logic [TW-1:0] diff;
    logic          prev_ge_start;
    logic          now_ge_prev;
    logic          diff_fits;

    assign diff          = f_now - f_prev;
    assign prev_ge_start = f_prev >= start_reg;
    assign now_ge_prev   = f_now >= f_prev;
    assign diff_fits     = (diff[TW-1:wrq_pkg::GAP_W] == '0);

    logic [MW-1:0] begin_mask;

    always_comb
    begin
        for (int i = 0; i < MW; i++)
        begin
            if (i < MAX_REQUIREMENTS)
            begin
                begin_mask[i] = (NW'(i) < active_n_reg);
            end
            else
            begin
                begin_mask[i] = 1'b0;
            end
        end
    end

    // per-entry observe update, all entries side by side
    logic [CW-1:0] cnt_inc [MAX_REQUIREMENTS];
    logic [MW-1:0] hit;
    logic [MW-1:0] done;

    always_comb
    begin
        logic          gap_ok;
        logic [CW-1:0] base;
        logic [CW-1:0] need_eff;
        hit  = '0;
        done = '0;
        for (int i = 0; i < MAX_REQUIREMENTS; i++)
        begin
            hit[i] = owed_reg[i] && (NW'(i) < active_n_reg) &&
                     (wit_reg[i] == f_samp_wit) && (f_samp_qual >= qual_reg[i]);
            gap_ok = (gap_reg[i] == '0) ||
                     (prev_ge_start && now_ge_prev && diff_fits &&
                      diff[wrq_pkg::GAP_W-1:0] <= gap_reg[i]);
            base   = (cnt_reg[i] != '0 && !gap_ok) ? '0 : cnt_reg[i];
            cnt_inc[i] = (base != wrq_pkg::COUNT_SATURATION) ? base + CW'(1) : base;
            need_eff   = (need_reg[i] == '0) ? CW'(1) : need_reg[i];
            done[i]    = cnt_inc[i] >= need_eff;
        end
    end

    always_comb
    begin
        owed_next  = owed_reg;
        bound_next = bound_reg;
        start_next = start_reg;
        for (int i = 0; i < MAX_REQUIREMENTS; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end
        if (proc)
        begin
            unique case (in_cmd_reg)
                wrq_pkg::CMD_BEGIN:
                begin
                    owed_next  = begin_mask;
                    bound_next = (active_n_reg == '0);
                    start_next = f_now;
                    for (int i = 0; i < MAX_REQUIREMENTS; i++)
                    begin
                        cnt_next[i] = '0;
                    end
                end
                wrq_pkg::CMD_OBSERVE:
                begin
                    for (int i = 0; i < MAX_REQUIREMENTS; i++)
                    begin
                        if (hit[i])
                        begin
                            cnt_next[i] = cnt_inc[i];
                            if (done[i])
                            begin
                                owed_next[i] = 1'b0;
                            end
                        end
                    end
                    bound_next = bound_reg || (owed_next == '0);
                end
                default:
                begin
                    // load and the unused code leave the binding state alone
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_reg  <= '0;
            bound_reg <= 1'b0;
            start_reg <= '0;
            for (int i = 0; i < MAX_REQUIREMENTS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            owed_reg  <= owed_next;
            bound_reg <= bound_next;
            start_reg <= start_next;
            for (int i = 0; i < MAX_REQUIREMENTS; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    // ---------------- result register ----------------
    logic          out_bound_reg;
    logic [MW-1:0] out_owed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (proc)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            out_bound_reg <= bound_next;
            out_owed_reg  <= owed_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(wrq_pkg::OUT_DATA_W - wrq_pkg::OUT_USED_W)'(0),
                            out_owed_reg, out_bound_reg};

    // ---------------- assertions ----------------
    a_owed_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (owed_reg & ~begin_mask & ~owed_reg) == '0 && (owed_reg >> MAX_REQUIREMENTS) == '0)
        else $error("debt bit set beyond the table");

    a_debt_only_from_begin: assert property (@(posedge clk) disable iff (!rst_n)
        !(proc && in_cmd_reg == wrq_pkg::CMD_BEGIN) |=> (owed_reg & ~$past(owed_reg)) == '0)
        else $error("debt bit raised outside a begin beat");

    a_bound_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && in_cmd_reg == wrq_pkg::CMD_OBSERVE && bound_reg) |=> bound_reg)
        else $error("observe beat cleared the bound flag");

    a_empty_begin_binds: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && in_cmd_reg == wrq_pkg::CMD_BEGIN && active_n_reg == '0)
        |=> (bound_reg && owed_reg == '0))
        else $error("begin with no requirements did not bind");

    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        proc |=> (out_owed_reg == owed_reg && out_bound_reg == bound_reg && m_valid_reg))
        else $error("result beat does not reflect the binding state");

endmodule

`default_nettype wire
